>>> sv/cfd_pkg.sv
// Shared types and constants for the configuration frame deframer.
`default_nettype none
package cfd_pkg;

  localparam logic [7:0]  START_CODE       = 8'hCA;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd64;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_OP   = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    OUT_NONE     = 3'd0,
    OUT_DATA     = 3'd1,
    OUT_ACCEPT   = 3'd2,
    OUT_MISMATCH = 3'd3,
    OUT_DROP     = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  data_value;
    logic [15:0] data_index;
    logic [15:0] frame_length;
    logic [7:0]  frame_opcode;
  } result_t;

endpackage
`default_nettype wire

>>> sv/cfd_in_stage.sv
// Input register stage: holds one received word until the parser consumes it.
`default_nettype none
module cfd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire cfd_pkg::in_item_t in_item,
  input  wire logic              consume,
  output logic                   item_valid,
  output cfd_pkg::in_item_t      item
);
  import cfd_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r, item_nxt;
  logic     take;

  assign in_tready = rst_n & (~valid_r | consume);
  assign take      = in_tvalid & in_tready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (take) begin
      valid_nxt = 1'b1;
      item_nxt  = in_item;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

>>> sv/cfd_core.sv
// Frame parser state machine with length, checksum and progress tracking.
`default_nettype none
module cfd_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [15:0]       cfg_wr_data,
  input  wire logic              advance,
  input  wire cfd_pkg::in_item_t item,
  output cfd_pkg::result_t       result
);
  import cfd_pkg::*;

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [15:0] expected_len_r, expected_len_nxt;
  logic [15:0] progress_r, progress_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  held_opcode_r, held_opcode_nxt;
  logic [15:0] max_length_r;
  logic [15:0] progress_inc;
  logic        drop;

  // A restart flag puts the parser back in hunting before this word is handled.
  assign phase_cur    = item.restart ? PH_HUNT : phase_r;
  assign progress_inc = progress_r + 16'd1;
  assign drop         = (progress_r >= expected_len_r) || (expected_len_r > max_length_r);

  always_comb begin
    phase_nxt = phase_cur;
    unique case (phase_cur)
      PH_HUNT: if (item.rx_byte == START_CODE) phase_nxt = PH_LEN;
      PH_LEN:  if (progress_r != 16'd0) phase_nxt = PH_OP;
      PH_OP:   phase_nxt = PH_DATA;
      PH_DATA: begin
        if (drop) begin
          phase_nxt = PH_HUNT;
        end else if (progress_inc == expected_len_r) begin
          phase_nxt = PH_SUM;
        end
      end
      PH_SUM:  phase_nxt = PH_HUNT;
      default: phase_nxt = PH_HUNT;
    endcase
  end

  always_comb begin
    expected_len_nxt = expected_len_r;
    progress_nxt     = progress_r;
    running_sum_nxt  = running_sum_r;
    held_opcode_nxt  = held_opcode_r;
    result           = '0;
    result.outcome   = OUT_NONE;
    unique case (phase_cur)
      PH_HUNT: begin
        if (item.rx_byte == START_CODE) begin
          expected_len_nxt = 16'd0;
          progress_nxt     = 16'd0;
          running_sum_nxt  = 8'd0;
        end
      end
      PH_LEN: begin
        // Length arrives low byte first.
        if (progress_r == 16'd0) begin
          expected_len_nxt = {expected_len_r[15:8], item.rx_byte};
          progress_nxt     = 16'd1;
        end else begin
          expected_len_nxt = {item.rx_byte, expected_len_r[7:0]};
          progress_nxt     = 16'd0;
        end
      end
      PH_OP: held_opcode_nxt = item.rx_byte;
      PH_DATA: begin
        if (drop) begin
          result.outcome = OUT_DROP;
        end else begin
          running_sum_nxt   = running_sum_r + item.rx_byte;
          result.outcome    = OUT_DATA;
          result.data_value = item.rx_byte;
          result.data_index = progress_r;
          progress_nxt      = progress_inc;
        end
      end
      PH_SUM: begin
        if (running_sum_r == item.rx_byte) begin
          result.outcome      = OUT_ACCEPT;
          result.frame_length = expected_len_r;
          result.frame_opcode = held_opcode_r;
        end else begin
          result.outcome = OUT_MISMATCH;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      expected_len_r <= 16'd0;
      progress_r     <= 16'd0;
      running_sum_r  <= 8'd0;
      held_opcode_r  <= 8'd0;
      max_length_r   <= MAX_LENGTH_RESET;
    end else begin
      if (advance) begin
        phase_r        <= phase_nxt;
        expected_len_r <= expected_len_nxt;
        progress_r     <= progress_nxt;
        running_sum_r  <= running_sum_nxt;
        held_opcode_r  <= held_opcode_nxt;
      end
      if (cfg_wr_en) begin
        max_length_r <= cfg_wr_data;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/cfd_out_stage.sv
// Result register: holds one result word until the downstream side takes it.
`default_nettype none
module cfd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire cfd_pkg::result_t result,
  output logic                  free,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output cfd_pkg::result_t      out_result
);
  import cfd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r, result_nxt;

  assign free = ~valid_r | out_tready;

  always_comb begin
    valid_nxt  = valid_r;
    result_nxt = result_r;
    if (load) begin
      valid_nxt  = 1'b1;
      result_nxt = result;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_result = result_r;

endmodule
`default_nettype wire

>>> sv/config_frame_deframer.sv
// Top level of the start-code / length / opcode / checksum frame deframer.
//
//  Channel | Direction | Payload
//  in_     | slave     | tdata: rx_byte; tuser: restart
//  out_    | master    | tdata: data_value, data_index, frame_length, frame_opcode;
//          |           | tuser: outcome
//  cfg_    | write     | cfg_wr_data: max_length
//
// A word is held in the input register until the parser loads its result into the result
// register, which it does once that register is free; out_tvalid is the result register's
// valid flag.
// The parser takes one word per cycle unless stalled; each word yields exactly one result.
// A stalled result register holds the parser, and the input register fills behind it.
// Synchronous reset returns the parser to start-code hunting and max_length to 64.
`default_nettype none
module config_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] data_value, [23:8] data_index,
                                       // [39:24] frame_length, [47:40] frame_opcode
  output logic [2:0]       out_tuser,  // [2:0] outcome
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data // [15:0] max_length
);
  import cfd_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     out_free;
  logic     advance;
  result_t  result;
  result_t  out_result;

  assign in_item.rx_byte = in_tdata;
  assign in_item.restart = in_tuser;
  assign advance         = item_valid & out_free;

  cfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .consume    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cfd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (item),
    .result      (result)
  );

  cfd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {out_result.frame_opcode, out_result.frame_length,
                      out_result.data_index, out_result.data_value};
  assign out_tuser = out_result.outcome;

endmodule
`default_nettype wire

>>> sv/cfd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
`default_nettype none
module cfd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [2:0]  out_tuser
);
  import cfd_pkg::*;

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // The parser never leaves a result word that is not a defined outcome.
  a_outcome_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == OUT_NONE || out_tuser == OUT_DATA ||
                    out_tuser == OUT_ACCEPT || out_tuser == OUT_MISMATCH ||
                    out_tuser == OUT_DROP))
    else $error("undefined outcome code");

  // Fields that do not belong to the outcome read as zero.
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == OUT_DATA |-> out_tdata[47:24] == 24'd0)
    else $error("frame fields set on a data word");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == OUT_NONE || out_tuser == OUT_MISMATCH ||
                   out_tuser == OUT_DROP) |-> out_tdata == 48'd0)
    else $error("payload set on a word without payload");

  // A result needs an accepted input word to pass through the input and result registers,
  // so nothing can show right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind config_frame_deframer cfd_checker u_cfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
